[rtl/sss_pkg.sv]
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types, constants and helpers for the streaming string substitute.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int unsigned MAX_PATTERN     = 8;
    localparam int unsigned MAX_REPLACEMENT = 8;

    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } reg_index_t;

    typedef enum logic {
        SRC_PATTERN     = 1'b0,
        SRC_REPLACEMENT = 1'b1
    } src_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    // One queued job: count bytes from a word, then optionally a literal byte
    typedef struct packed {
        src_t       src;
        logic [3:0] count;
        logic       has_byte;
        logic [7:0] lit_byte;
    } cmd_t;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_len;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_len;
    } cfg_t;

    function automatic logic [7:0] byte_sel(input logic [63:0] word, input logic [2:0] idx);
        byte_sel = word[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [3:0] eff_pattern_len(input logic [3:0] len);
        if (len == 4'd0)
            eff_pattern_len = 4'd1;
        else if (len > 4'(MAX_PATTERN))
            eff_pattern_len = 4'(MAX_PATTERN);
        else
            eff_pattern_len = len;
    endfunction

    function automatic logic [3:0] eff_replacement_len(input logic [3:0] len);
        if (len > 4'(MAX_REPLACEMENT))
            eff_replacement_len = 4'(MAX_REPLACEMENT);
        else
            eff_replacement_len = len;
    endfunction

endpackage

[rtl/sss_front.sv]
// ----------------------------------------------------------------------------
// sss_front
// Accepts input words, tracks the partial match and issues output jobs.
// ----------------------------------------------------------------------------
module sss_front (
    input  logic              clk,
    input  logic              rst_n,
    input  sss_pkg::cfg_t     cfg,
    input  logic              match_clear,
    input  logic              in_valid,
    output logic              in_ready,
    input  sss_pkg::in_item_t in_data,
    input  logic              queue_full,
    output logic              push,
    output sss_pkg::cmd_t     push_cmd
);

    logic [3:0] matched_reg;
    logic [3:0] matched_next;
    logic [3:0] plen;
    logic [3:0] rlen;
    logic [3:0] matched_inc;
    logic [7:0] expect_byte;
    logic       accept;
    logic       need_push;

    assign plen        = sss_pkg::eff_pattern_len(cfg.pattern_len);
    assign rlen        = sss_pkg::eff_replacement_len(cfg.replacement_len);
    assign matched_inc = matched_reg + 4'd1;
    assign expect_byte = sss_pkg::byte_sel(cfg.pattern_bytes, matched_reg[2:0]);
    assign in_ready    = !queue_full;
    assign accept      = in_valid && in_ready;
    assign push        = accept && need_push;

    always_comb
    begin
        push_cmd.src      = sss_pkg::SRC_PATTERN;
        push_cmd.count    = matched_reg;
        push_cmd.has_byte = 1'b0;
        push_cmd.lit_byte = in_data.in_byte;
        need_push         = 1'b0;
        matched_next      = 4'd0;
        priority if (in_data.end_of_input)
        begin
            need_push = (matched_reg != 4'd0);
        end
        else if (in_data.in_byte == expect_byte)
        begin
            if (matched_inc >= plen)
            begin
                push_cmd.src   = sss_pkg::SRC_REPLACEMENT;
                push_cmd.count = rlen;
                need_push      = (rlen != 4'd0);
            end
            else
            begin
                matched_next = matched_inc;
            end
        end
        else
        begin
            push_cmd.has_byte = 1'b1;
            need_push         = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            matched_reg <= 4'd0;
        else if (match_clear)
            matched_reg <= 4'd0;
        else if (accept)
            matched_reg <= matched_next;
    end

endmodule

[rtl/sss_queue.sv]
// ----------------------------------------------------------------------------
// sss_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module sss_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sss_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output sss_pkg::cmd_t head
);

    sss_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;

    assign full  = (fill_reg == 2'd2);
    assign empty = (fill_reg == 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

endmodule

[rtl/sss_back.sv]
// ----------------------------------------------------------------------------
// sss_back
// Expands queued jobs into output words, one byte per cycle while out_ready allows it.
// ----------------------------------------------------------------------------
module sss_back (
    input  logic               clk,
    input  logic               rst_n,
    input  sss_pkg::cfg_t      cfg,
    input  logic               queue_empty,
    input  sss_pkg::cmd_t      head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output sss_pkg::out_item_t out_data
);

    logic [3:0]         idx_reg;
    logic               out_valid_reg;
    sss_pkg::out_item_t out_data_reg;
    logic               load;
    logic [3:0]         total;
    logic [3:0]         idx_inc;
    logic               is_last;
    logic [63:0]        src_word;
    logic [7:0]         next_byte;

    assign load     = !queue_empty && (!out_valid_reg || out_ready);
    assign total    = head.count + 4'(head.has_byte);
    assign idx_inc  = idx_reg + 4'd1;
    assign is_last  = (idx_inc == total);
    assign pop      = load && is_last;
    assign src_word = (head.src == sss_pkg::SRC_REPLACEMENT) ? cfg.replacement_bytes
                                                             : cfg.pattern_bytes;
    assign next_byte = (idx_reg < head.count) ? sss_pkg::byte_sel(src_word, idx_reg[2:0])
                                              : head.lit_byte;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.out_byte <= next_byte;
            out_data_reg.last     <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= is_last ? 4'd0 : idx_inc;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

[rtl/stream_string_substitute.sv]
// ----------------------------------------------------------------------------
// stream_string_substitute
// Byte stream copier that replaces each occurrence of a target pattern.
// ----------------------------------------------------------------------------
// One input word is accepted per cycle while the two-entry job queue has room.
// An input causing n output words occupies the output register for each word
// (at most 8 for a mismatch after a seven-byte partial match), so sustained
// throughput is bounded by the single-byte output port; words that give no
// output or one output run at one per cycle while the job queue has room.
// Registers sit at byte addresses 0x00, 0x08, 0x10, 0x18; writing the pattern
// or its length drops any held partial match.
module stream_string_substitute (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sss_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output sss_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sss_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sss_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sss_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    sss_pkg::cfg_t       cfg_reg;
    sss_pkg::reg_index_t reg_idx;
    logic                wr_en;
    logic                match_clear;
    logic                queue_full;
    logic                queue_empty;
    logic                push;
    logic                pop;
    sss_pkg::cmd_t       push_cmd;
    sss_pkg::cmd_t       head;

    assign pready      = 1'b1;
    assign reg_idx     = sss_pkg::reg_index_t'(paddr[4:3]);
    assign wr_en       = psel && penable && pwrite && pready;
    assign match_clear = wr_en && (reg_idx == sss_pkg::REG_PATTERN_BYTES ||
                                   reg_idx == sss_pkg::REG_PATTERN_LENGTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pattern_bytes     <= 64'd0;
            cfg_reg.pattern_len       <= 4'd1;
            cfg_reg.replacement_bytes <= 64'd0;
            cfg_reg.replacement_len   <= 4'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sss_pkg::REG_PATTERN_BYTES:      cfg_reg.pattern_bytes     <= pwdata;
                sss_pkg::REG_PATTERN_LENGTH:     cfg_reg.pattern_len       <= pwdata[3:0];
                sss_pkg::REG_REPLACEMENT_BYTES:  cfg_reg.replacement_bytes <= pwdata;
                sss_pkg::REG_REPLACEMENT_LENGTH: cfg_reg.replacement_len   <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sss_pkg::REG_PATTERN_BYTES:      prdata = cfg_reg.pattern_bytes;
            sss_pkg::REG_PATTERN_LENGTH:     prdata = {60'd0, cfg_reg.pattern_len};
            sss_pkg::REG_REPLACEMENT_BYTES:  prdata = cfg_reg.replacement_bytes;
            sss_pkg::REG_REPLACEMENT_LENGTH: prdata = {60'd0, cfg_reg.replacement_len};
        endcase
    end

    sss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .match_clear (match_clear),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    sss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head)
    );

    sss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (queue_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
